/* src/three_class_strict_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue_defines
// Assertion macros used by the checker file of the priority queue.
// ----------------------------------------------------------------------------
`ifndef THREE_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes of the three class strict priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int PKT_ID_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 6;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

  localparam logic [CLASS_W-1:0] CLS_HIGH    = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_MEDIUM  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_LOW     = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 2'd3;

  typedef struct packed {
    logic accept;   // request taken this cycle
    logic load_id;  // head id read back, copy to output
  } dp_cmd_t;

  typedef struct packed {
    logic any_queued;
  } dp_stat_t;

endpackage

/* src/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Class FIFO storage, head/tail pointers, occupancy and the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spq_pkg::dp_cmd_t               cmd,
  output spq_pkg::dp_stat_t              stat,
  input  logic                           op,
  input  logic [spq_pkg::PKT_ID_W-1:0]   pkt_id,
  input  logic [spq_pkg::CLASS_W-1:0]    pkt_class,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output logic [spq_pkg::PKT_ID_W-1:0]   out_id,
  output logic [spq_pkg::CLASS_W-1:0]    out_class,
  output logic                           all_empty,
  output logic [spq_pkg::TOTAL_W-1:0]    total_count
);
  import spq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam int SUM_W  = OCC_W + 2;
  localparam int MEM_N  = NUM_CLASSES * QUEUE_DEPTH;

  localparam logic [OCC_W-1:0]  OCC_FULL = OCC_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [ID_BITS-1:0] mem [MEM_N];
  logic [ID_BITS-1:0] rd_data;

  logic [PTR_W-1:0] head      [NUM_CLASSES];
  logic [PTR_W-1:0] tail      [NUM_CLASSES];
  logic [OCC_W-1:0] occ       [NUM_CLASSES];
  logic [PTR_W-1:0] head_next [NUM_CLASSES];
  logic [PTR_W-1:0] tail_next [NUM_CLASSES];
  logic [OCC_W-1:0] occ_next  [NUM_CLASSES];

  logic [NUM_CLASSES-1:0] enq_hit;
  logic [NUM_CLASSES-1:0] deq_hit;
  logic                   found;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [STATUS_W-1:0]    res_status;
  logic [CLASS_W-1:0]     res_class;
  logic [SUM_W-1:0]       sum;

  logic [ID_BITS+PKT_ID_W-1:0] wr_ext;
  logic [ID_BITS+PKT_ID_W-1:0] rd_ext;
  logic [SUM_W+TOTAL_W-1:0]    sum_ext;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign wr_ext  = {{ID_BITS{1'b0}}, pkt_id};
  assign rd_ext  = {{PKT_ID_W{1'b0}}, rd_data};
  assign sum_ext = {{TOTAL_W{1'b0}}, sum};

  always_comb begin
    found      = 1'b0;
    enq_hit    = '0;
    deq_hit    = '0;
    wr_addr    = '0;
    rd_addr    = '0;
    res_class  = CLS_HIGH;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_next[c] = head[c];
      tail_next[c] = tail[c];
      occ_next[c]  = occ[c];
      enq_hit[c]   = (op == OP_ENQ) && (pkt_class == CLASS_W'(c)) && (occ[c] != OCC_FULL);
      if (pkt_class == CLASS_W'(c)) begin
        wr_addr = ADDR_W'(c * QUEUE_DEPTH) + ADDR_W'(tail[c]);
      end
      if (!found && occ[c] != '0) begin
        found      = 1'b1;
        deq_hit[c] = (op == OP_DEQ);
        rd_addr    = ADDR_W'(c * QUEUE_DEPTH) + ADDR_W'(head[c]);
        if (op == OP_DEQ) begin
          res_class = CLASS_W'(c);
        end
      end
      if (enq_hit[c]) begin
        tail_next[c] = next_ptr(tail[c]);
        occ_next[c]  = occ[c] + 1'b1;
      end
      if (deq_hit[c]) begin
        head_next[c] = next_ptr(head[c]);
        occ_next[c]  = occ[c] - 1'b1;
      end
    end
    if (op == OP_ENQ) begin
      if (pkt_class == CLS_UNKNOWN) begin
        res_status = STAT_UNKNOWN;
      end else if (|enq_hit) begin
        res_status = STAT_OK;
      end else begin
        res_status = STAT_FULL;
      end
    end else begin
      res_status = found ? STAT_OK : STAT_EMPTY;
    end
    sum = SUM_W'(occ_next[0]) + SUM_W'(occ_next[1]) + SUM_W'(occ_next[2]);
  end

  assign stat.any_queued = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        occ[c]  <= '0;
      end
    end else if (cmd.accept) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= head_next[c];
        tail[c] <= tail_next[c];
        occ[c]  <= occ_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && |enq_hit) begin
      mem[wr_addr] <= wr_ext[ID_BITS-1:0];
    end
    if (cmd.accept && |deq_hit) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status      <= res_status;
      out_class   <= res_class;
      all_empty   <= (sum == '0);
      total_count <= sum_ext[TOTAL_W-1:0];
      out_id      <= '0;
    end else if (cmd.load_id) begin
      out_id      <= rd_ext[PKT_ID_W-1:0];
    end
  end

endmodule

/* src/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake control: request acceptance, head read wait, result valid.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  output logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;
  logic   wants_read;

  assign slot_free  = (state == ST_IDLE) && (!out_valid || !out_stall);
  assign in_stall   = !slot_free;
  assign cmd.accept = slot_free && in_valid;
  assign cmd.load_id = (state == ST_READ);
  assign wants_read = cmd.accept && (op == OP_DEQ) && stat.any_queued;

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        state_next = wants_read ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if ((cmd.accept && !wants_read) || cmd.load_id) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/three_class_strict_priority_queue.sv */
// Enqueue: result registered when the request is taken; one enqueue per cycle
// while in_stall is low. Dequeue: the head id from the shared id memory is
// registered, then copied to out_id in the read state, which stalls requests;
// an empty dequeue skips it. Reset clears pointers, occupancy and the result
// valid; the id memory is not cleared and is only read after it is written.
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue
// Strict priority scheduler with high, medium and low class FIFOs.
// ----------------------------------------------------------------------------
module three_class_strict_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [spq_pkg::PKT_ID_W-1:0]  pkt_id,
  input  logic [spq_pkg::CLASS_W-1:0]   pkt_class,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::PKT_ID_W-1:0]  out_id,
  output logic [spq_pkg::CLASS_W-1:0]   out_class,
  output logic                          all_empty,
  output logic [spq_pkg::TOTAL_W-1:0]   total_count
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .pkt_id      (pkt_id),
    .pkt_class   (pkt_class),
    .status      (status),
    .out_id      (out_id),
    .out_class   (out_class),
    .all_empty   (all_empty),
    .total_count (total_count)
  );

endmodule

/* src/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_class_strict_priority_queue_defines.svh"

module spq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [spq_pkg::STATUS_W-1:0]  status,
  input logic [spq_pkg::PKT_ID_W-1:0]  out_id,
  input logic [spq_pkg::CLASS_W-1:0]   out_class
);
  import spq_pkg::*;

  `SPQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_id) && $stable(status), "stalled result changed")

  `SPQ_ASSERT_IMP(a_no_take_when_blocked, clk, rst, out_valid && out_stall, in_stall, "request taken while result blocked")

  `SPQ_ASSERT_IMP(a_id_zero_on_fail, clk, rst, out_valid && status != STAT_OK, out_id == '0, "id set on failed request")

  `SPQ_ASSERT_IMP(a_class_range, clk, rst, out_valid, out_class != CLS_UNKNOWN, "result class out of range")

endmodule

bind three_class_strict_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_id    (out_id),
  .out_class (out_class)
);
